// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the integer decoder.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== src/derint_pkg.sv =====
// Package for the DER INTEGER decoder: widths, codes, state struct and helpers.
// Depends on nothing; used by every module of the decoder.
`timescale 1ns / 1ps

package derint_pkg;

   localparam int BYTE_W              = 8;
   localparam int CONTENT_W           = 32;
   localparam int VALUE_W             = 64;
   localparam int STATUS_W            = 3;
   localparam int HDR_W               = 3;
   localparam int REQ_TDATA_W         = 8;
   localparam int RSP_TDATA_W         = 72;
   localparam int LENGTH_BITS_DEFAULT = 32;

   localparam logic [BYTE_W-1:0]    TAG_INTEGER = 8'h02;
   localparam logic [BYTE_W-1:0]    FORM_LONG   = 8'h80;
   localparam logic [BYTE_W-1:0]    FORM_LONG_1 = 8'h81;
   localparam logic [BYTE_W-1:0]    FORM_LONG_4 = 8'h84;
   localparam logic [CONTENT_W-1:0] MAX_CONTENT = 32'd9;
   localparam logic [HDR_W-1:0]     SHORT_HDR   = 3'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_HEADER = 3'd1,
      STATUS_WRONG_TAG  = 3'd2,
      STATUS_TOO_SMALL  = 3'd3,
      STATUS_RANGE      = 3'd4
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    tag;
      logic [BYTE_W-1:0]    form;
      logic [CONTENT_W-1:0] content_len;
      logic [BYTE_W-1:0]    first;
      logic [VALUE_W-1:0]   sum;
   } derint_state_type;

   // Header length in bytes for a length byte; zero marks an invalid form.
   function automatic logic [HDR_W-1:0] hdr_len(input logic [BYTE_W-1:0] form);
      logic [HDR_W-1:0] len;
      len = '0;
      if (form < FORM_LONG) begin
         len = SHORT_HDR;
      end else if (form inside {[FORM_LONG_1:FORM_LONG_4]}) begin
         len = SHORT_HDR + HDR_W'(form - FORM_LONG);
      end
      return len;
   endfunction

endpackage

// ===== src/derint_parse.sv =====
// Byte parser of the DER INTEGER decoder: holds the per-buffer state registers
// and computes their next values from each byte. Depends on derint_pkg.
`timescale 1ns / 1ps

module derint_parse #(
   parameter int LENGTH_BITS = derint_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [derint_pkg::BYTE_W-1:0]    data_byte,
   input  logic                             last_byte,
   output derint_pkg::derint_state_type     state_in,
   output logic [LENGTH_BITS-1:0]           count_in
);
   import derint_pkg::*;

   localparam int CMP_W = (LENGTH_BITS > CONTENT_W) ? LENGTH_BITS : CONTENT_W;

   derint_state_type       state_ff;
   logic [LENGTH_BITS-1:0] count_ff;
   logic [HDR_W-1:0]       hdr;
   logic [LENGTH_BITS-1:0] hdr_ext;
   logic [LENGTH_BITS-1:0] k;
   logic                   take_content;

   assign hdr     = hdr_len(state_ff.form);
   assign hdr_ext = LENGTH_BITS'(hdr);
   assign k       = count_ff - hdr_ext;
   assign take_content = (CMP_W'(k) < CMP_W'(state_ff.content_len)) &&
                         (k < LENGTH_BITS'(MAX_CONTENT));

   always_comb begin
      state_in = state_ff;
      if (count_ff == '0) begin
         state_in.tag = data_byte;
      end else if (count_ff == LENGTH_BITS'(1)) begin
         state_in.form        = data_byte;
         state_in.content_len = (data_byte < FORM_LONG) ? CONTENT_W'(data_byte) : '0;
      end else if (hdr != '0 && count_ff < hdr_ext) begin
         state_in.content_len = {state_ff.content_len[CONTENT_W-BYTE_W-1:0], data_byte};
      end else if (hdr != '0 && take_content) begin
         if (k == '0) begin
            state_in.first = data_byte;
         end
         state_in.sum = {state_ff.sum[VALUE_W-BYTE_W-1:0], data_byte};
      end
      // The byte count saturates at its all-ones value.
      count_in = (count_ff != '1) ? count_ff + LENGTH_BITS'(1) : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         if (last_byte) begin
            state_ff <= '0;
            count_ff <= '0;
         end else begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

endmodule

// ===== src/derint_judge.sv =====
// Result evaluation of the DER INTEGER decoder: runs the ordered status checks
// on the state as it stands after the last byte. Depends on derint_pkg.
`timescale 1ns / 1ps

module derint_judge #(
   parameter int LENGTH_BITS = derint_pkg::LENGTH_BITS_DEFAULT
) (
   input  derint_pkg::derint_state_type     state_in,
   input  logic [LENGTH_BITS-1:0]           count_in,
   output derint_pkg::status_type           status,
   output logic [derint_pkg::VALUE_W-1:0]   value
);
   import derint_pkg::*;

   localparam int CMP_W = (LENGTH_BITS > CONTENT_W + 1) ? LENGTH_BITS : CONTENT_W + 1;

   logic [HDR_W-1:0] hdr;
   logic [CMP_W-1:0] need;
   logic [CMP_W-1:0] total;

   assign hdr   = hdr_len(state_in.form);
   assign need  = CMP_W'(hdr) + CMP_W'(state_in.content_len);
   assign total = CMP_W'(count_in);

   always_comb begin
      value = '0;
      if (total < CMP_W'(SHORT_HDR) || hdr == '0 || total < CMP_W'(hdr)) begin
         status = STATUS_BAD_HEADER;
      end else if (state_in.tag != TAG_INTEGER) begin
         status = STATUS_WRONG_TAG;
      end else if (need > total) begin
         status = STATUS_TOO_SMALL;
      end else if (state_in.content_len != '0 && state_in.first[BYTE_W-1]) begin
         status = STATUS_RANGE;
      end else if (state_in.content_len > MAX_CONTENT ||
                   (state_in.content_len == MAX_CONTENT && state_in.first != '0)) begin
         status = STATUS_RANGE;
      end else begin
         status = STATUS_OK;
         value  = state_in.sum;
      end
   end

endmodule

// ===== src/der_integer_decoder.sv =====
// Latency: a result appears in the cycle after its last byte is accepted.
// Throughput: one byte per cycle. The input waits only while a finished result
// sits in the result register and the receiver is not ready; a result taken in
// the same cycle frees the register, so bytes then keep flowing without a gap.
// Reset: synchronous, active high; it clears the parse state, the byte count
// and the result valid flag. No clearing pass is needed.
`timescale 1ns / 1ps

module der_integer_decoder #(
   parameter int LENGTH_BITS = derint_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Input item stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [derint_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [7:0] data_byte
   input  logic                                req_tlast,  // last_byte
   // Result item stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [derint_pkg::RSP_TDATA_W-1:0]  rsp_tdata   // [2:0] status, [66:3] value,
                                                           // [71:67] zero
);
   import derint_pkg::*;

   localparam int PAD_W = RSP_TDATA_W - STATUS_W - VALUE_W;

   // An item is taken whenever the result register is empty or is being
   // drained in the same cycle, so a new byte can enter every cycle.
   logic                   accept;
   derint_state_type       state_in;
   logic [LENGTH_BITS-1:0] count_in;
   status_type             status;
   logic [VALUE_W-1:0]     value;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // The parser keeps tag, length byte, content length, first content byte
   // and the shifted-in value, and clears all of it after the last byte.
   derint_parse #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata[BYTE_W-1:0]),
      .last_byte (req_tlast),
      .state_in  (state_in),
      .count_in  (count_in)
   );

   // The status checks look at the state including the byte being accepted.
   derint_judge #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_judge (
      .state_in (state_in),
      .count_in (count_in),
      .status   (status),
      .value    (value)
   );

   // Only a last byte produces a result; otherwise a taken result retires.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}}, value, status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/derint_checker.sv =====
// Port-level checker for the DER INTEGER decoder, bound to the top level.
// Depends on derint_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module derint_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic                                req_tlast,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [derint_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import derint_pkg::*;

   logic last_taken;
   logic rsp_stall;
   logic not_ok;
   logic value_zero;

   assign last_taken = req_tvalid && req_tready && req_tlast;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign not_ok     = rsp_tdata[STATUS_W-1:0] != STATUS_OK;
   assign value_zero = rsp_tdata[STATUS_W +: VALUE_W] == '0;

   // Reset empties the result register.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   // A stalled result holds its data.
   `ASSERT_NEXT(a_stall_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // Every accepted last byte yields a result in the next cycle.
   `ASSERT_NEXT(a_last_result, clock, reset, last_taken, rsp_tvalid)
   // Without a last byte and with nothing stalled, no result appears.
   `ASSERT_NEXT(a_no_spurious, clock, reset, !last_taken && !rsp_stall, !rsp_tvalid)
   // A failing status carries a zero value.
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_tvalid && not_ok, value_zero)

endmodule

bind der_integer_decoder derint_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/testbench.sv =====
// Self-checking testbench for der_integer_decoder, the streaming DER INTEGER decoder.
// It depends on derint_pkg for the status codes and the tag and length constants.
`timescale 1ns / 1ps

module testbench;
   import derint_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 6;
   // The longest correct run is about 2000 bytes with gaps and receiver stalls;
   // this limit leaves it a wide margin.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int RANDOM_BYTES = 1600;
   localparam int BURST_BYTES  = 300;
   localparam int STALL_CYCLES = 300;
   localparam int IDLE_PERCENT = 32;
   localparam int SHOWN_ERRORS = 30;
   localparam logic [CONTENT_W-1:0] COUNT_MAX = '1;

   typedef logic [BYTE_W-1:0] byte_queue_type[$];

   typedef struct {
      status_type         status;
      logic [VALUE_W-1:0] value;
   } decode_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic                   req_tlast  = 1'b0; // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [2:0] status, [66:3] value, [71:67] zero

   // Both sides idle at random only while this is set.
   bit idle_on = 1'b0;
   // Cycles left in a forced receiver hold-off.
   int hold_left = 0;

   int mismatch_count = 0;
   int bytes_sent = 0;
   int buffers_sent = 0;
   int results_seen = 0;
   int status_tally[5];

   // Shadow copy of the decoder's parse state.
   logic [CONTENT_W-1:0] seen_count = '0;
   logic [BYTE_W-1:0]    seen_tag   = '0;
   logic [BYTE_W-1:0]    seen_form  = '0;
   logic [CONTENT_W-1:0] item_len   = '0;
   logic [BYTE_W-1:0]    lead_byte  = '0;
   logic [VALUE_W-1:0]   acc_value  = '0;

   decode_result_type pending_decodes[$];

   der_integer_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   // The run is cut off here if the decoder hangs.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               pending_decodes.size());
      $display("testbench failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < SHOWN_ERRORS) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Number of header bytes that a length byte implies; zero for an illegal form.
   function automatic int header_bytes(input logic [BYTE_W-1:0] form);
      if (form < FORM_LONG) begin
         return 2;
      end
      if (form >= FORM_LONG_1 && form <= FORM_LONG_4) begin
         return 2 + int'(form - FORM_LONG);
      end
      return 0;
   endfunction

   // Advances the shadow state by one accepted byte. On the buffer's last byte it
   // works out the status and value that the decoder must return, queues them and
   // clears the state, just as the decoder does.
   task automatic decode_byte(input logic [BYTE_W-1:0] data, input logic last);
      longint unsigned pos;
      longint unsigned hdr;
      longint unsigned offset;
      longint unsigned total;
      decode_result_type result;

      pos = seen_count;
      hdr = header_bytes(seen_form);
      if (pos == 0) begin
         seen_tag = data;
      end else if (pos == 1) begin
         seen_form = data;
         item_len = (data < FORM_LONG) ? CONTENT_W'(data) : '0;
      end else if (hdr != 0 && pos < hdr) begin
         // Long-form length bytes arrive most significant first.
         item_len = {item_len[CONTENT_W-BYTE_W-1:0], data};
      end else if (hdr != 0) begin
         // Only the first nine content bytes matter; the rest and any trailing
         // bytes after the item are just counted.
         offset = pos - hdr;
         if (offset < item_len && offset < MAX_CONTENT) begin
            if (offset == 0) begin
               lead_byte = data;
            end
            acc_value = (acc_value << BYTE_W) + VALUE_W'(data);
         end
      end
      if (seen_count != COUNT_MAX) begin
         seen_count = seen_count + 1'b1;
      end
      if (!last) begin
         return;
      end

      total = seen_count;
      hdr = header_bytes(seen_form);
      result.value = '0;
      if (total < 2 || hdr == 0 || total < hdr) begin
         result.status = STATUS_BAD_HEADER;
      end else if (seen_tag != TAG_INTEGER) begin
         result.status = STATUS_WRONG_TAG;
      end else if (hdr + longint'(item_len) > total) begin
         result.status = STATUS_TOO_SMALL;
      end else if (item_len != 0 && lead_byte[BYTE_W-1]) begin
         // A set sign bit means a negative integer.
         result.status = STATUS_RANGE;
      end else if (item_len > MAX_CONTENT || (item_len == MAX_CONTENT && lead_byte != 0)) begin
         result.status = STATUS_RANGE;
      end else begin
         result.status = STATUS_OK;
         result.value = acc_value;
      end
      pending_decodes.push_back(result);
      status_tally[int'(result.status)]++;

      seen_count = '0;
      seen_tag   = '0;
      seen_form  = '0;
      item_len   = '0;
      lead_byte  = '0;
      acc_value  = '0;
   endtask

   // Offers one byte and waits until the decoder takes it. The valid flag stays
   // high after the handshake, so back-to-back bytes never drop it. While idling
   // is on, each cycle before the byte is left empty with the idle probability.
   task automatic send_byte(input logic [BYTE_W-1:0] data, input logic last);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      bytes_sent++;
      decode_byte(data, last);
   endtask

   task automatic send_buffer(input byte_queue_type der_bytes);
      foreach (der_bytes[i]) begin
         send_byte(der_bytes[i], i == der_bytes.size() - 1);
      end
      buffers_sent++;
   endtask

   function automatic logic [BYTE_W-1:0] content_byte(input bit leading);
      int pick;
      pick = $urandom_range(3);
      if (leading) begin
         // Leading byte: zero pad, positive, sign bit set, or anything.
         case (pick)
            0: return 8'h00;
            1: return BYTE_W'($urandom_range(1, 127));
            2: return BYTE_W'($urandom_range(128, 255));
            default: return BYTE_W'($urandom);
         endcase
      end
      case (pick)
         0: return 8'h00;
         1: return 8'hFF;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // Builds one buffer. Most are well-formed INTEGER encodings with random
   // content; the rest are noise, wrong tags, over-long contents, truncated items,
   // bad length forms and items with trailing bytes.
   function automatic byte_queue_type random_der();
      byte_queue_type der_bytes;
      int kind;
      int content_len;
      int len_bytes;
      int cut;
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(1, 6)) der_bytes.push_back(BYTE_W'($urandom));
         return der_bytes;
      end
      if (kind < 17) begin
         // The largest value that fits: a zero pad and eight 0xFF bytes.
         der_bytes = {TAG_INTEGER, 8'h09, 8'h00};
         repeat (8) der_bytes.push_back(8'hFF);
         return der_bytes;
      end

      der_bytes.push_back(($urandom_range(19) == 0) ? BYTE_W'($urandom) : TAG_INTEGER);
      kind = $urandom_range(99);
      content_len = (kind < 10) ? 0 : (kind < 75) ? $urandom_range(1, 9) :
                    (kind < 88) ? MAX_CONTENT : $urandom_range(10, 14);
      kind = $urandom_range(99);
      if (kind < 70) begin
         der_bytes.push_back(BYTE_W'(content_len));
      end else if (kind < 90) begin
         len_bytes = $urandom_range(1, 4);
         der_bytes.push_back(FORM_LONG + BYTE_W'(len_bytes));
         for (int i = len_bytes - 1; i >= 0; i--) begin
            der_bytes.push_back(BYTE_W'(content_len >> (8 * i)));
         end
      end else if (kind < 94) begin
         // A long form whose length bytes are random, usually far too long.
         len_bytes = $urandom_range(1, 4);
         der_bytes.push_back(FORM_LONG + BYTE_W'(len_bytes));
         repeat (len_bytes) der_bytes.push_back(BYTE_W'($urandom));
      end else begin
         der_bytes.push_back(($urandom_range(1) == 0) ? FORM_LONG :
                             BYTE_W'($urandom_range(int'(FORM_LONG_4) + 1, 255)));
      end
      for (int i = 0; i < content_len; i++) begin
         der_bytes.push_back(content_byte(i == 0));
      end

      kind = $urandom_range(99);
      if (kind < 10) begin
         cut = $urandom_range(1, der_bytes.size() - 1);
         repeat (cut) void'(der_bytes.pop_back());
      end else if (kind < 25) begin
         repeat ($urandom_range(1, 3)) der_bytes.push_back(BYTE_W'($urandom));
      end
      return der_bytes;
   endfunction

   // Receiver: ready drops at random while idling is on, and stays low for the
   // whole of a forced hold-off.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (idle_on) begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Each result taken is compared with the oldest expected one.
   always @(posedge clock) begin : check_results
      decode_result_type want;
      logic [STATUS_W-1:0] got_status;
      logic [VALUE_W-1:0]  got_value;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status = rsp_tdata[STATUS_W-1:0];
         got_value  = rsp_tdata[STATUS_W +: VALUE_W];
         results_seen++;
         if (pending_decodes.size() == 0) begin
            report_mismatch($sformatf("unexpected result, status %0d value 0x%h",
                                      got_status, got_value));
         end else begin
            want = pending_decodes.pop_front();
            if (got_status !== want.status) begin
               report_mismatch($sformatf("result %0d: status %0d, expected %s",
                                         results_seen, got_status, want.status.name()));
            end
            if (got_value !== want.value) begin
               report_mismatch($sformatf("result %0d: value 0x%h, expected 0x%h",
                                         results_seen, got_value, want.value));
            end
            if (rsp_tdata[RSP_TDATA_W-1:STATUS_W+VALUE_W] !== '0) begin
               report_mismatch($sformatf("result %0d: padding bits not zero", results_seen));
            end
         end
      end
   end

   // One short buffer for every header error, a wrong tag, a truncated item, the
   // zero-length case, a negative value and an item followed by trailing bytes.
   task automatic test_directed_cases();
      send_buffer({8'hFF});                       // too short for a header
      send_buffer({TAG_INTEGER, 8'h00});          // empty content decodes to zero
      send_buffer({TAG_INTEGER, FORM_LONG});      // indefinite length is illegal
      send_buffer({TAG_INTEGER, 8'hFF});          // length form above four bytes
      send_buffer({8'h03, 8'h01, 8'h05});         // tag is not INTEGER
      send_buffer({TAG_INTEGER, 8'h82, 8'h00});   // ends inside the length bytes
      send_buffer({TAG_INTEGER, 8'h03, 8'h01});   // item longer than the buffer
      send_buffer({TAG_INTEGER, 8'h01, 8'h80});   // negative
      send_buffer({TAG_INTEGER, 8'h01, 8'h7F, 8'hAA}); // trailing byte is ignored
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_back_to_back();
      int start_count;
      idle_on = 1'b0;
      start_count = bytes_sent;
      while (bytes_sent - start_count < BURST_BYTES) begin
         send_buffer(random_der());
      end
   endtask

   // The receiver holds off for a long stretch while short buffers keep coming,
   // so the result register fills and the decoder must stall its input.
   task automatic test_output_stall();
      idle_on = 1'b0;
      hold_left = STALL_CYCLES;
      repeat (20) send_buffer({TAG_INTEGER, 8'h01, BYTE_W'($urandom_range(0, 127))});
      repeat (10) send_buffer(random_der());
   endtask

   // The bulk of the run: random buffers with random gaps on both sides.
   task automatic test_random_buffers();
      int start_count;
      idle_on = 1'b1;
      start_count = bytes_sent;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         send_buffer(random_der());
      end
   endtask

   initial begin : run_tests
      int waited;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_back_to_back();
      test_output_stall();
      test_random_buffers();

      @(negedge clock);
      req_tvalid <= 1'b0;
      idle_on = 1'b0;

      // Let the last results drain, then keep watching for any stray output.
      waited = 0;
      while (pending_decodes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (pending_decodes.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_decodes.size()));
      end

      $display("Sent %0d bytes in %0d buffers, checked %0d results, %0d mismatches.",
               bytes_sent, buffers_sent, results_seen, mismatch_count);
      $display("Status counts: ok %0d, header %0d, tag %0d, too small %0d, range %0d.",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3],
               status_tally[4]);
      if (mismatch_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
